[hw/rtl/polyev_pkg.sv]
// shared types and constants for the polynomial evaluator
`timescale 1ns / 1ps
`default_nettype none

package polyev_pkg;

   localparam int MAX_TERMS  = 7;
   localparam int FRAC_BITS  = 16;
   localparam int ACC_W      = 32;
   localparam int X_W        = 24;
   localparam int TERMS_W    = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // number of horner steps after the leading coefficient
   localparam int STEPS = MAX_TERMS - 1;

   // datapath widths
   localparam int PROD_W = ACC_W + X_W;
   localparam int RSUM_W = PROD_W + 1;
   localparam int RND_W  = RSUM_W - FRAC_BITS;
   localparam int TOT_W  = ((RND_W > ACC_W) ? RND_W : ACC_W) + 1;

   localparam int COEFF_IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

   // register map
   localparam logic [CSR_IDX_W-1:0] REG_TERMS      = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_COEFF_BASE = CSR_IDX_W'(1);

   typedef logic signed [ACC_W-1:0] coeff_type;
   typedef coeff_type [MAX_TERMS-1:0] coeff_array_type;

   typedef struct packed {
      logic [TERMS_W-1:0] terms;
      coeff_array_type    coeffs;
   } cfg_type;

   typedef struct packed {
      logic signed [X_W-1:0] sample_x;
      logic                  batch_end_in;
   } req_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] value_y;
      logic                    overflowed;
      logic                    batch_end_out;
   } rsp_type;

   // one sample moving down the horner chain
   typedef struct packed {
      logic [ACC_W-1:0]   acc;
      logic [X_W-1:0]     x;
      logic [TERMS_W-1:0] terms;
      logic               ovf;
      logic               last;
   } stage_type;

endpackage

`default_nettype wire

[hw/rtl/polyev_csr.sv]
// configuration registers: term count and coefficients
`timescale 1ns / 1ps
`default_nettype none

module polyev_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [polyev_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [polyev_pkg::CSR_DATA_W-1:0] csr_wdata,
   output polyev_pkg::cfg_type                   cfg
);
   import polyev_pkg::*;

   logic [TERMS_W-1:0]   terms_ff, terms_in;
   coeff_array_type      coeffs_ff, coeffs_in;
   logic [CSR_IDX_W-1:0] coeff_sel;

   assign coeff_sel = csr_index - REG_COEFF_BASE;

   always_comb begin
      terms_in  = terms_ff;
      coeffs_in = coeffs_ff;
      if (csr_we) begin
         if (csr_index == REG_TERMS) begin
            terms_in = csr_wdata[TERMS_W-1:0];
         end else if (32'(coeff_sel) < 32'(MAX_TERMS)) begin
            coeffs_in[coeff_sel[COEFF_IDX_W-1:0]] = csr_wdata[ACC_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         terms_ff  <= TERMS_W'(1);
         coeffs_ff <= '0;
      end else begin
         terms_ff  <= terms_in;
         coeffs_ff <= coeffs_in;
      end
   end

   assign cfg.terms  = terms_ff;
   assign cfg.coeffs = coeffs_ff;

endmodule

`default_nettype wire

[hw/rtl/polyev_step.sv]
// one horner step: multiply stage, then round, add coefficient and saturate
`timescale 1ns / 1ps
`default_nettype none

module polyev_step (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [polyev_pkg::TERMS_W-1:0] step_idx,
   input  wire polyev_pkg::coeff_type          coeff,
   input  wire logic                           in_valid,
   input  wire polyev_pkg::stage_type          in_tok,
   output logic                                out_valid,
   output polyev_pkg::stage_type               out_tok
);
   import polyev_pkg::*;

   // stage a: product
   logic                     a_valid_ff;
   stage_type                a_tok_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;

   // stage b: rounded sum
   logic                  b_valid_ff;
   stage_type             b_tok_ff, b_tok_in;
   logic [RSUM_W-1:0]     rsum;
   logic [RND_W-1:0]      rnd;
   logic [TOT_W-1:0]      total;
   logic                  sat_hit;
   logic [ACC_W-1:0]      sat_val;
   logic                  active;

   localparam logic [RSUM_W-1:0] ROUND_HALF = RSUM_W'(1) << (FRAC_BITS - 1);

   assign prod_in = $signed(in_tok.acc) * $signed(in_tok.x);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      a_tok_ff <= in_tok;
      prod_ff  <= prod_in;
   end

   always_comb begin
      // round half up, then floor by dropping the fraction bits
      rsum    = {prod_ff[PROD_W-1], prod_ff} + ROUND_HALF;
      rnd     = rsum[RSUM_W-1:FRAC_BITS];
      total   = {{(TOT_W-RND_W){rnd[RND_W-1]}}, rnd}
              + {{(TOT_W-ACC_W){coeff[ACC_W-1]}}, coeff};
      // out of range when the bits above the result sign disagree with it
      sat_hit = (total[TOT_W-1:ACC_W-1] != {(TOT_W-ACC_W+1){1'b0}}) &&
                (total[TOT_W-1:ACC_W-1] != {(TOT_W-ACC_W+1){1'b1}});
      if (!sat_hit) begin
         sat_val = total[ACC_W-1:0];
      end else if (total[TOT_W-1]) begin
         sat_val = {1'b1, {(ACC_W-1){1'b0}}};
      end else begin
         sat_val = {1'b0, {(ACC_W-1){1'b1}}};
      end
      active   = step_idx < a_tok_ff.terms;
      b_tok_in = a_tok_ff;
      if (active) begin
         b_tok_in.acc = sat_val;
         b_tok_in.ovf = a_tok_ff.ovf | sat_hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      b_tok_ff <= b_tok_in;
   end

   assign out_valid = b_valid_ff;
   assign out_tok   = b_tok_ff;

endmodule

`default_nettype wire

[hw/rtl/polynomial_evaluator.sv]
// top level of the pipelined horner polynomial evaluator
`timescale 1ns / 1ps
`default_nettype none

// polynomial evaluator, y = c0*x^(t-1) + ... + c(t-1), signed q16.16 fixed point
//
// channels
//   request: start with req_data (sample_x q8.16, batch_end_in); a transaction
//     is taken at every edge with start high and busy low. busy is always low,
//     so a new sample can enter on every cycle.
//   response: rsp_strobe marks rsp_data for exactly one cycle; the receiver
//     cannot hold it off, and none is needed since the pipeline never stalls.
//   csr: csr_we, csr_index, csr_wdata write one register per edge; index 0 is
//     the term count, indexes 1 to 7 are coeff_0 to coeff_6. write only while
//     no samples are in flight.
// throughput and pipeline
//   one sample per cycle. the result strobes after passing one entry register,
//   then two registers for each of the six horner steps (multiply stage,
//   round/add/saturate stage).
// reset
//   synchronous, clears every valid bit in the chain, sets the term count to
//   one and every coefficient to zero.

module polynomial_evaluator (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire polyev_pkg::req_type               req_data,
   output logic                                   rsp_strobe,
   output polyev_pkg::rsp_type                    rsp_data,
   input  wire logic                              csr_we,
   input  wire logic [polyev_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [polyev_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import polyev_pkg::*;

   cfg_type            cfg;

   // chain position 0 is the entry register, position k the output of step k
   logic               chain_valid [STEPS+1];
   stage_type          chain_tok   [STEPS+1];

   logic               s0_valid_ff, s0_valid_in;
   stage_type          s0_tok_ff, s0_tok_in;
   logic [TERMS_W-1:0] terms_clamped;

   // pipeline never backs up
   assign busy = 1'b0;

   polyev_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // entry stage: load the leading coefficient as the starting accumulator
   always_comb begin
      s0_valid_in = start & ~busy;
      if (32'(cfg.terms) > 32'(MAX_TERMS)) begin
         terms_clamped = TERMS_W'(MAX_TERMS);
      end else begin
         terms_clamped = cfg.terms;
      end
      s0_tok_in.x     = req_data.sample_x;
      s0_tok_in.last  = req_data.batch_end_in;
      s0_tok_in.terms = terms_clamped;
      s0_tok_in.ovf   = 1'b0;
      // empty polynomial evaluates to zero
      s0_tok_in.acc   = (terms_clamped == '0) ? '0 : cfg.coeffs[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s0_tok_ff <= s0_tok_in;
   end

   assign chain_valid[0] = s0_valid_ff;
   assign chain_tok[0]   = s0_tok_ff;

   // one step per remaining coefficient; a step past the term count passes
   // the accumulator through untouched
   for (genvar k = 1; k <= STEPS; k++) begin : g_step
      polyev_step u_step (
         .clock     (clock),
         .reset     (reset),
         .step_idx  (TERMS_W'(k)),
         .coeff     (cfg.coeffs[k]),
         .in_valid  (chain_valid[k-1]),
         .in_tok    (chain_tok[k-1]),
         .out_valid (chain_valid[k]),
         .out_tok   (chain_tok[k])
      );
   end

   // response straight from the last step's registers
   assign rsp_strobe             = chain_valid[STEPS];
   assign rsp_data.value_y       = chain_tok[STEPS].acc;
   assign rsp_data.overflowed    = chain_tok[STEPS].ovf;
   assign rsp_data.batch_end_out = chain_tok[STEPS].last;

   // a single term or none never saturates
   a_ovf_needs_step: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.overflowed |-> chain_tok[STEPS].terms >= TERMS_W'(2))
      else $error("overflow flagged with fewer than two terms");

   // empty polynomial gives zero without overflow
   a_zero_terms: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (chain_tok[STEPS].terms == '0) |->
         (rsp_data.value_y == '0) && !rsp_data.overflowed)
      else $error("nonzero result for zero terms");

   if (STEPS > 0) begin : g_chk
      // every transaction entering the chain reaches step one, through its multiply and round/add/saturate registers
      a_step_advance: assert property (@(posedge clock) disable iff (reset)
         s0_valid_ff |-> ##2 chain_valid[1])
         else $error("transaction lost between entry and first step");
   end

endmodule

`default_nettype wire

[sim/tb_polynomial_evaluator.sv]
// self-checking testbench for the pipelined horner polynomial evaluator
`timescale 1ns / 1ps

module tb_polynomial_evaluator;
   import polyev_pkg::*;

   // run limits and pipeline timing
   localparam int LIMIT_CYCLES = 200000;
   localparam int DRAIN_CYCLES = 16;      // outlasts the pipeline latency, with some margin
   localparam int ITEMS_PER_PHASE = 250;

   // fixed point landmarks
   localparam int ONE_Q16 = 65536;
   localparam int X_MAX = (1 << (X_W - 1)) - 1;
   localparam int X_MIN = -(1 << (X_W - 1));
   localparam logic [ACC_W-1:0] C_MAX = 32'h7FFF_FFFF;
   localparam logic [ACC_W-1:0] C_MIN = 32'h8000_0000;
   localparam longint S32_MAX = 64'sd2147483647;
   localparam longint S32_MIN = -64'sd2147483648;
   localparam longint HALF_LSB = longint'(1) <<< (FRAC_BITS - 1);

   // how wide a random value may range
   typedef enum int {SPAN_FULL, SPAN_TAME, SPAN_EDGE} span_type;

   // expected-value tracker: mirrors the csr state and predicts each sample's result
   class horner_scoreboard;
      logic [TERMS_W-1:0] terms_q;
      coeff_array_type    coeff_q;
      rsp_type            expected_y[$];
      int                 failures;

      function new();
         terms_q  = TERMS_W'(1);
         coeff_q  = '0;
         failures = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == REG_TERMS) begin
            terms_q = data[TERMS_W-1:0];
         end else begin
            coeff_q[idx - REG_COEFF_BASE] = data[ACC_W-1:0];
         end
      endfunction

      // horner chain with round half up and per-step saturation
      function rsp_type horner_eval(req_type s);
         rsp_type y;
         longint  acc;
         longint  rnd;
         longint  sum;
         int      n;
         n = (terms_q > MAX_TERMS) ? MAX_TERMS : int'(terms_q);
         acc = 0;
         y.overflowed = 1'b0;
         if (n > 0) begin
            acc = longint'($signed(coeff_q[0]));
            for (int k = 1; k < n; k++) begin
               rnd = (acc * longint'($signed(s.sample_x)) + HALF_LSB) >>> FRAC_BITS;
               sum = rnd + longint'($signed(coeff_q[k]));
               if (sum > S32_MAX) begin
                  sum = S32_MAX;
                  y.overflowed = 1'b1;
               end else if (sum < S32_MIN) begin
                  sum = S32_MIN;
                  y.overflowed = 1'b1;
               end
               acc = sum;
            end
         end
         y.value_y = acc[ACC_W-1:0];
         y.batch_end_out = s.batch_end_in;
         return y;
      endfunction

      function void note_sample(req_type s);
         expected_y.push_back(horner_eval(s));
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_y.size() == 0) begin
            $display("%0t: result with nothing expected, value_y %0d overflowed %0b",
                     $time, got.value_y, got.overflowed);
            failures++;
            return;
         end
         want = expected_y.pop_front();
         if (got.value_y !== want.value_y) begin
            $display("%0t: value_y expected %0d actual %0d", $time, want.value_y, got.value_y);
            failures++;
         end
         if (got.overflowed !== want.overflowed) begin
            $display("%0t: overflowed expected %0b actual %0b", $time,
                     want.overflowed, got.overflowed);
            failures++;
         end
         if (got.batch_end_out !== want.batch_end_out) begin
            $display("%0t: batch_end_out expected %0b actual %0b", $time,
                     want.batch_end_out, got.batch_end_out);
            failures++;
         end
      endfunction

      function int pending();
         return expected_y.size();
      endfunction
   endclass

   // dut signals, all inputs known from time zero
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   req_type               req_data = '0;
   logic                  rsp_strobe;
   rsp_type               rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int unsigned      cycle_count = 0;
   horner_scoreboard horner_sb = new();

   polynomial_evaluator u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // watchdog: a hung pipeline or lost result ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("FAIL polynomial_evaluator");
         $finish;
      end
   end

   // monitor: values read here are the ones present before this edge
   always @(posedge clock) begin
      if (!reset) begin
         // request transaction taken at this edge
         if (start && !busy) begin
            horner_sb.note_sample(req_data);
         end
         // response transaction, the receiver has no say in its timing
         if (rsp_strobe) begin
            horner_sb.check_result(rsp_data);
         end
      end
   end

   // random value helpers
   function automatic coeff_type random_coeff(span_type span);
      case (span)
         SPAN_FULL: return $urandom();
         SPAN_TAME: return int'($urandom_range(0, 1 << 19)) - (1 << 18);   // about +-4.0
         default: begin
            case ($urandom_range(4))
               0: return C_MAX;
               1: return C_MIN;
               2: return '0;
               3: return 32'sd1;
               default: return -32'sd1;
            endcase
         end
      endcase
   endfunction

   function automatic req_type make_sample(int x);
      req_type s;
      s.sample_x = x[X_W-1:0];
      s.batch_end_in = 1'($urandom_range(1));
      return s;
   endfunction

   function automatic req_type random_sample(span_type span);
      int x;
      case (span)
         SPAN_FULL: x = $urandom();
         SPAN_TAME: x = int'($urandom_range(0, 1 << 18)) - (1 << 17);       // about +-2.0
         default: begin
            case ($urandom_range(6))
               0: x = X_MAX;
               1: x = X_MIN;
               2: x = 0;
               3: x = 1;
               4: x = -1;
               5: x = ONE_Q16;
               default: x = -ONE_Q16;
            endcase
         end
      endcase
      return make_sample(x);
   endfunction

   // one csr write; the caller lowers csr_we after the last of a series
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      horner_sb.write_reg(idx, data);
   endtask

   // program term count and all coefficients, junk in the unused term bits
   task automatic load_poly(input logic [TERMS_W-1:0] terms, input coeff_array_type c);
      logic [CSR_DATA_W-1:0] term_word;
      term_word = $urandom();
      term_word[TERMS_W-1:0] = terms;
      write_csr(REG_TERMS, term_word);
      for (int k = 0; k < MAX_TERMS; k++) begin
         write_csr(REG_COEFF_BASE + CSR_IDX_W'(k), c[k]);
      end
      csr_we <= 1'b0;
   endtask

   // stop sending and let the pipeline empty before touching the csrs
   task automatic settle();
      start <= 1'b0;
      while (horner_sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // send one sample, with random idle cycles ahead of it
   task automatic send_sample(input req_type s, input int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= s;
      do @(posedge clock); while (busy);
   endtask

   initial begin
      coeff_array_type  c;
      logic [TERMS_W-1:0] terms;
      span_type         style;
      span_type         x_span;
      int               idle_pct [3] = '{0, 58, 31};
      int               sent;
      int               block_len;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset defaults: one term, zero coefficient
      send_sample(make_sample(ONE_Q16), 0);
      send_sample(make_sample(-1), 0);

      // zero terms: empty sum regardless of coefficients
      settle();
      for (int k = 0; k < MAX_TERMS; k++) c[k] = random_coeff(SPAN_FULL);
      load_poly('0, c);
      send_sample(make_sample(X_MAX), 0);
      send_sample(make_sample(X_MIN), 0);

      // single term passes coeff_0 through
      settle();
      load_poly(TERMS_W'(1), {MAX_TERMS{C_MIN}});
      send_sample(make_sample(0), 0);
      send_sample(make_sample(X_MAX), 0);

      // one lsb times halves: rounding ties go toward plus infinity
      settle();
      c = '0;
      c[0] = 32'sd1;
      load_poly(TERMS_W'(2), c);
      send_sample(make_sample(ONE_Q16 / 2), 0);
      send_sample(make_sample(-ONE_Q16 / 2), 0);
      send_sample(make_sample(3 * ONE_Q16 / 2), 0);
      send_sample(make_sample(-3 * ONE_Q16 / 2), 0);

      // full length with largest coefficients, saturation both ways
      settle();
      load_poly(TERMS_W'(MAX_TERMS), {MAX_TERMS{C_MAX}});
      send_sample(make_sample(X_MAX), 0);
      send_sample(make_sample(X_MIN), 0);
      send_sample(make_sample(ONE_Q16), 0);
      send_sample(make_sample(0), 0);

      settle();
      load_poly(TERMS_W'(MAX_TERMS), {MAX_TERMS{C_MIN}});
      send_sample(make_sample(X_MAX), 0);
      send_sample(make_sample(X_MIN), 0);
      send_sample(make_sample(-1), 0);
      send_sample(make_sample(1), 0);

      // ordinary quadratic 3x^2 - 2x + 0.5
      settle();
      c = '0;
      c[0] = 3 * ONE_Q16;
      c[1] = -2 * ONE_Q16;
      c[2] = ONE_Q16 / 2;
      load_poly(TERMS_W'(3), c);
      send_sample(make_sample(ONE_Q16), 0);
      send_sample(make_sample(-ONE_Q16), 0);
      send_sample(make_sample(1), 0);
      send_sample(make_sample(-1), 0);
      send_sample(make_sample(2 * ONE_Q16), 0);

      // random blocks, each with a fresh polynomial; phases differ in sender idling
      foreach (idle_pct[p]) begin
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            settle();
            // half the blocks stay in range so results come from deep in the chain
            case ($urandom_range(3))
               0, 1: style = SPAN_TAME;
               2: style = SPAN_FULL;
               default: style = SPAN_EDGE;
            endcase
            terms = ($urandom_range(9) == 0) ? '0 : TERMS_W'($urandom_range(1, MAX_TERMS));
            for (int k = 0; k < MAX_TERMS; k++) begin
               c[k] = random_coeff((style == SPAN_EDGE) ? span_type'($urandom_range(2)) : style);
            end
            load_poly(terms, c);
            block_len = $urandom_range(8, 40);
            repeat (block_len) begin
               if (style == SPAN_TAME && $urandom_range(9) != 0) begin
                  x_span = SPAN_TAME;
               end else begin
                  x_span = span_type'($urandom_range(2));
               end
               send_sample(random_sample(x_span), idle_pct[p]);
            end
            sent += block_len;
         end
      end

      // wait out the pipeline, then give the verdict
      settle();
      if (horner_sb.failures == 0) begin
         $display("PASS polynomial_evaluator");
      end else begin
         $display("FAIL polynomial_evaluator");
      end
      $finish;
   end

endmodule
